/* hdl/rsps_pkg.sv */
// ----------------------------------------------------------------------------
// Road segment point sampler package
// Shared constants, the arctangent table and the sequencer state type.
// ----------------------------------------------------------------------------
package rsps_pkg;

	localparam int MAX_POINTS_DEF  = 64;
	localparam int ANGLE_ITER_DEF  = 16;
	localparam int TABLE_LEN       = 24;

	localparam int MUL_AW = 48;
	localparam int MUL_BW = 40;
	localparam int MUL_PW = 88;
	localparam int DIV_NW = 34;
	localparam int DIV_DW = 24;

	localparam logic [15:0] STEP_RESET = 16'd1000;
	localparam logic [33:0] GAIN_Q30   = 34'd652032874;
	localparam logic [38:0] INV_PI_Q40 = 39'd349985421133;
	localparam logic [15:0] RECIP6_Q18 = 16'd43691;

	localparam logic [0:0] REG_SAMPLE_STEP = 1'b0;

	typedef enum logic [19:0] {
		S_IDLE = 20'b0000_0000_0000_0000_0001,
		S_DIVL = 20'b0000_0000_0000_0000_0010,
		S_CNT  = 20'b0000_0000_0000_0000_0100,
		S_PT   = 20'b0000_0000_0000_0000_1000,
		S_M1   = 20'b0000_0000_0000_0001_0000,
		S_M2   = 20'b0000_0000_0000_0010_0000,
		S_M3   = 20'b0000_0000_0000_0100_0000,
		S_M4   = 20'b0000_0000_0000_1000_0000,
		S_SA   = 20'b0000_0000_0001_0000_0000,
		S_CR1  = 20'b0000_0000_0010_0000_0000,
		S_DVL  = 20'b0000_0000_0100_0000_0000,
		S_DIV2 = 20'b0000_0000_1000_0000_0000,
		S_CR2  = 20'b0000_0001_0000_0000_0000,
		S_M5L  = 20'b0000_0010_0000_0000_0000,
		S_M5   = 20'b0000_0100_0000_0000_0000,
		S_M5R  = 20'b0000_1000_0000_0000_0000,
		S_M6   = 20'b0001_0000_0000_0000_0000,
		S_M6R  = 20'b0010_0000_0000_0000_0000,
		S_SUM  = 20'b0100_0000_0000_0000_0000,
		S_EMIT = 20'b1000_0000_0000_0000_0000
	} state_t;

	// Arctangent of 2^-i as a fraction of a full turn, 2^32 units per turn.
	function automatic logic [33:0] atan_turn(input logic [4:0] idx);
		logic [33:0] v;
		begin
			case (idx)
				5'd0:  v = 34'd536870912;
				5'd1:  v = 34'd316933406;
				5'd2:  v = 34'd167458907;
				5'd3:  v = 34'd85004756;
				5'd4:  v = 34'd42667331;
				5'd5:  v = 34'd21354465;
				5'd6:  v = 34'd10679838;
				5'd7:  v = 34'd5340245;
				5'd8:  v = 34'd2670163;
				5'd9:  v = 34'd1335087;
				5'd10: v = 34'd667544;
				5'd11: v = 34'd333772;
				5'd12: v = 34'd166886;
				5'd13: v = 34'd83443;
				5'd14: v = 34'd41722;
				5'd15: v = 34'd20861;
				5'd16: v = 34'd10430;
				5'd17: v = 34'd5215;
				5'd18: v = 34'd2608;
				5'd19: v = 34'd1304;
				5'd20: v = 34'd652;
				5'd21: v = 34'd326;
				5'd22: v = 34'd163;
				5'd23: v = 34'd81;
				default: v = 34'd0;
			endcase
			return v;
		end
	endfunction

endpackage

/* hdl/road_segment_point_sampler_unit.sv */
// Per segment, set-up is a 34-step division of the length by the step; each
// point is then worked out on the shared units, an arc whose half angle is not
// small taking two rotations and one 34-step division, and each point waits at
// the output for as long as tready is held low.
// Throughput: one segment at a time; the input stays not ready until the last
// point of the segment has been taken. Reset clears the sequencer, the output
// valid and sets sample_step to 1000; no memory needs clearing.
// ----------------------------------------------------------------------------
// Road segment point sampler
// Samples a straight line or a circular arc at a fixed step and emits the
// points with a small sequencer driving a radix-16 multiplier, a restoring
// divider and a rotation unit, one step each per cycle.
// ----------------------------------------------------------------------------
module road_segment_point_sampler_unit #(
	parameter int MAX_POINTS       = rsps_pkg::MAX_POINTS_DEF,
	parameter int ANGLE_ITERATIONS = rsps_pkg::ANGLE_ITER_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// Input segment stream.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // start_x, start_y, heading, seg_length, curvature
	input  logic [0:0]   s_tuser,  // req_type
	// Output point stream.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,  // point_x, point_y
	output logic         m_tlast,  // last
	output logic [0:0]   m_tuser,  // truncated
	// Configuration port.
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import rsps_pkg::*;

	// Point counter wide enough to hold the cap itself.
	localparam int CW = $clog2(MAX_POINTS + 1);

	state_t state_q;

	// Configuration register.
	logic [15:0] step_q;
	logic [15:0] step_eff;

	// Segment held for the duration of its transactions.
	logic               arc_q;
	logic signed [31:0] x0_q, y0_q;
	logic [15:0]        head_q;
	logic [23:0]        len_q;
	logic               kneg_q;
	logic [23:0]        kmag_q;

	logic [23:0]   whole_q;
	logic          remnz_q;
	logic [CW-1:0] count_q, idx_q;
	logic          cut_q;
	logic [24:0]   sacc_q;
	logic [23:0]   s_q;
	logic [47:0]   mag_q;
	logic [31:0]   phi_q, theta_q;
	logic signed [35:0] a_q;
	logic          aneg_q;
	logic          mneg_q;
	logic signed [39:0] dx_q, dy_q;

	// Shared units.
	logic [5:0]          cnt_q;
	logic [MUL_AW-1:0]   ma_q;
	logic [MUL_BW-1:0]   mb_q;
	logic [MUL_PW-1:0]   acc_q;
	logic [3:0]          mnd_q;
	logic [DIV_NW-1:0]   dn_q;
	logic [DIV_DW-1:0]   dr_q, dd_q;
	logic signed [33:0]  cx_q, cy_q, cz_q;
	logic [1:0]          cquad_q;

	// Output register.
	logic               m_tvalid_q;
	logic signed [31:0] px_q, py_q;
	logic               last_q, trunc_q;

	// ------------------------------------------------------------------
	// Configuration port: writes complete in the access phase, no wait states.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SAMPLE_STEP) ? {16'd0, step_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_SAMPLE_STEP) begin
			step_q <= pwdata[15:0];
		end
	end

	// A step of zero is taken as one millimetre.
	assign step_eff = (step_q == 16'd0) ? 16'd1 : step_q;

	// ------------------------------------------------------------------
	// Multiplier: unsigned, one four-bit digit of the left-aligned operand
	// per cycle, most significant first.
	// ------------------------------------------------------------------
	logic [MUL_PW-1:0] acc_n;
	logic [43:0]       mdig;
	logic              mul_done;

	assign mdig     = ma_q[MUL_AW-1 -: 4] * mb_q;
	assign acc_n    = {acc_q[MUL_PW-5:0], 4'd0} + {{(MUL_PW-44){1'b0}}, mdig};
	assign mul_done = (cnt_q[3:0] == mnd_q - 4'd1);

	// ------------------------------------------------------------------
	// Divider: restoring, one quotient bit per cycle.
	// ------------------------------------------------------------------
	logic [DIV_DW:0]   rem_sh;
	logic [DIV_DW+1:0] rem_diff;
	logic              qbit;
	logic [DIV_DW-1:0] dr_n;
	logic [DIV_NW-1:0] dn_n;
	logic              div_done;

	assign rem_sh   = {dr_q, dn_q[DIV_NW-1]};
	assign rem_diff = {1'b0, rem_sh} - {2'b00, dd_q};
	assign qbit     = !rem_diff[DIV_DW+1];
	assign dr_n     = qbit ? rem_diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
	assign dn_n     = {dn_q[DIV_NW-2:0], qbit};
	assign div_done = (cnt_q == 6'(DIV_NW - 1));

	// ------------------------------------------------------------------
	// Rotation unit: one shift-and-add step per cycle, quadrant folded in
	// on the way in and undone on the way out.
	// ------------------------------------------------------------------
	logic signed [33:0] sh_x, sh_y, at_w, cx_n, cy_n, cz_n;
	logic signed [33:0] cos_w, sin_w;
	logic               cor_done;

	assign sh_x     = cx_q >>> cnt_q[4:0];
	assign sh_y     = cy_q >>> cnt_q[4:0];
	assign at_w     = $signed(atan_turn(cnt_q[4:0]));
	assign cx_n     = cz_q[33] ? cx_q + sh_y : cx_q - sh_y;
	assign cy_n     = cz_q[33] ? cy_q - sh_x : cy_q + sh_x;
	assign cz_n     = cz_q[33] ? cz_q + at_w : cz_q - at_w;
	assign cor_done = (cnt_q == 6'(ANGLE_ITERATIONS - 1));

	always_comb begin
		case (cquad_q)
			2'd0: begin
				cos_w = cx_q;
				sin_w = cy_q;
			end
			2'd1: begin
				cos_w = -cy_q;
				sin_w = cx_q;
			end
			2'd2: begin
				cos_w = -cx_q;
				sin_w = -cy_q;
			end
			default: begin
				cos_w = cy_q;
				sin_w = -cx_q;
			end
		endcase
	end

	// Angle presented to the rotation unit on load: the heading once the
	// chord is known, otherwise the half angle for the chord division.
	logic [31:0] rot_ang;
	logic [31:0] rot_bias;
	logic [1:0]  rot_quad;
	logic [31:0] rot_res;

	always_comb begin
		rot_ang  = aneg_q ? theta_q : phi_q;
		rot_bias = rot_ang + 32'h2000_0000;
		rot_quad = rot_bias[31:30];
		rot_res  = rot_ang - {rot_quad, 30'd0};
	end

	// ------------------------------------------------------------------
	// Datapath helpers.
	// ------------------------------------------------------------------
	logic [24:0]        total_w;
	logic [23:0]        s_w;
	logic [31:0]        r_w, phi_w, theta_w;
	logic [13:0]        v6_w;
	logic [29:0]        corr_w;
	logic [34:0]        ps2_w;
	logic [33:0]        psmag_w;
	logic signed [35:0] q_w;
	logic [35:0]        amag_w;
	logic [33:0]        cmag_w, smag_w;
	logic [68:0]        prod_w;
	logic signed [69:0] sp_w, rnd_w;
	logic signed [40:0] sumx_w, sumy_w;
	logic signed [31:0] satx_w, saty_w;
	logic [31:0]        head32_w;

	assign head32_w = {head_q, 16'd0};
	assign total_w  = {1'b0, whole_q} + 25'd1 + {24'd0, remnz_q};
	assign s_w      = ({{(24-CW){1'b0}}, idx_q} <= whole_q) ? sacc_q[23:0] : len_q;
	assign r_w      = acc_n[71:40];
	assign phi_w    = kneg_q ? 32'd0 - r_w : r_w;
	assign theta_w  = head32_w + phi_w;
	assign v6_w     = acc_q[43:30];
	assign corr_w   = 30'((v6_w * RECIP6_Q18) >> 18);
	assign ps2_w    = {sin_w, 1'b0};
	assign psmag_w  = ps2_w[34] ? 34'(-ps2_w) : ps2_w[33:0];
	assign q_w      = aneg_q ? -$signed({2'b00, dn_n}) : $signed({2'b00, dn_n});
	assign amag_w   = a_q[35] ? 36'(-a_q) : a_q;
	assign cmag_w   = cos_w[33] ? 34'(-cos_w) : cos_w;
	assign smag_w   = sin_w[33] ? 34'(-sin_w) : sin_w;
	assign prod_w   = acc_q[68:0];
	assign sp_w     = mneg_q ? -$signed({1'b0, prod_w}) : $signed({1'b0, prod_w});
	assign rnd_w    = sp_w + 70'sd536870912;
	assign sumx_w   = {{9{x0_q[31]}}, x0_q} + {dx_q[39], dx_q};
	assign sumy_w   = {{9{y0_q[31]}}, y0_q} + {dy_q[39], dy_q};

	always_comb begin
		if (sumx_w > 41'sd2147483647) begin
			satx_w = 32'sh7FFF_FFFF;
		end else if (sumx_w < -41'sd2147483648) begin
			satx_w = 32'sh8000_0000;
		end else begin
			satx_w = sumx_w[31:0];
		end
		if (sumy_w > 41'sd2147483647) begin
			saty_w = 32'sh7FFF_FFFF;
		end else if (sumy_w < -41'sd2147483648) begin
			saty_w = 32'sh8000_0000;
		end else begin
			saty_w = sumy_w[31:0];
		end
	end

	// ------------------------------------------------------------------
	// Sequencer and unit registers.
	// ------------------------------------------------------------------
	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						arc_q   <= s_tuser[0];
						x0_q    <= s_tdata[31:0];
						y0_q    <= s_tdata[63:32];
						head_q  <= s_tdata[79:64];
						len_q   <= s_tdata[103:80];
						kneg_q  <= s_tdata[127];
						kmag_q  <= s_tdata[127] ? 24'd0 - s_tdata[127:104] : s_tdata[127:104];
						dn_q    <= {10'd0, s_tdata[103:80]};
						dr_q    <= '0;
						dd_q    <= {8'd0, step_eff};
						cnt_q   <= '0;
						state_q <= S_DIVL;
					end
				end
				S_DIVL: begin
					dn_q  <= dn_n;
					dr_q  <= dr_n;
					cnt_q <= cnt_q + 6'd1;
					if (div_done) begin
						whole_q <= dn_n[23:0];
						remnz_q <= (dr_n != '0);
						state_q <= S_CNT;
					end
				end
				S_CNT: begin
					cut_q   <= total_w > 25'(MAX_POINTS);
					count_q <= (total_w > 25'(MAX_POINTS)) ? CW'(MAX_POINTS) : total_w[CW-1:0];
					idx_q   <= '0;
					sacc_q  <= '0;
					state_q <= S_PT;
				end
				S_PT: begin
					s_q    <= s_w;
					sacc_q <= sacc_q + {9'd0, step_eff};
					cnt_q  <= '0;
					if (arc_q && kmag_q != 24'd0) begin
						ma_q    <= {s_w, 24'd0};
						mb_q    <= {16'd0, kmag_q};
						acc_q   <= '0;
						mnd_q   <= 4'd6;
						state_q <= S_M1;
					end else begin
						// A line or a zero-curvature arc: the chord is the path length itself.
						a_q     <= {12'd0, s_w};
						theta_q <= head32_w;
						aneg_q  <= 1'b1;
						mneg_q  <= 1'b0;
						state_q <= S_SA;
					end
				end
				S_M1: begin
					acc_q <= acc_n;
					ma_q  <= {ma_q[MUL_AW-5:0], 4'd0};
					cnt_q <= cnt_q + 6'd1;
					if (mul_done) begin
						mag_q   <= acc_n[47:0];
						ma_q    <= acc_n[47:0];
						mb_q    <= {1'b0, INV_PI_Q40};
						acc_q   <= '0;
						mnd_q   <= 4'd12;
						cnt_q   <= '0;
						state_q <= S_M2;
					end
				end
				S_M2: begin
					acc_q <= acc_n;
					ma_q  <= {ma_q[MUL_AW-5:0], 4'd0};
					cnt_q <= cnt_q + 6'd1;
					if (mul_done) begin
						phi_q   <= phi_w;
						theta_q <= theta_w;
						cnt_q   <= '0;
						if (mag_q < 48'h400_0000) begin
							ma_q    <= {3'd0, mag_q[25:1], 20'd0};
							mb_q    <= {15'd0, mag_q[25:1]};
							acc_q   <= '0;
							mnd_q   <= 4'd7;
							state_q <= S_M3;
						end else begin
							aneg_q  <= 1'b0;
							state_q <= S_SA;
						end
					end
				end
				S_M3: begin
					acc_q <= acc_n;
					ma_q  <= {ma_q[MUL_AW-5:0], 4'd0};
					cnt_q <= cnt_q + 6'd1;
					if (mul_done) begin
						ma_q    <= {s_q, 24'd0};
						mb_q    <= {20'd0, acc_n[49:30]};
						acc_q   <= '0;
						mnd_q   <= 4'd6;
						cnt_q   <= '0;
						state_q <= S_M4;
					end
				end
				S_M4: begin
					acc_q <= acc_n;
					ma_q  <= {ma_q[MUL_AW-5:0], 4'd0};
					cnt_q <= cnt_q + 6'd1;
					if (mul_done) begin
						aneg_q  <= 1'b1;
						a_q     <= '0;
						cnt_q   <= '0;
						state_q <= S_SA;
						mneg_q  <= 1'b1;
					end
				end
				S_SA: begin
					// Rotation set-up: either the chord is known (a line, a small arc whose
					// chord is finished here, or after the division) and the heading is rotated,
					// or the half angle is rotated first for the chord division.
					cx_q    <= $signed(GAIN_Q30);
					cy_q    <= '0;
					cz_q    <= {{2{rot_res[31]}}, rot_res};
					cquad_q <= rot_quad;
					cnt_q   <= '0;
					if (aneg_q) begin
						if (mneg_q) begin
							a_q <= {12'd0, s_q} - {6'd0, corr_w};
						end
						state_q <= S_CR2;
					end else begin
						state_q <= S_CR1;
					end
					mneg_q <= 1'b0;
				end
				S_CR1: begin
					cx_q  <= cx_n;
					cy_q  <= cy_n;
					cz_q  <= cz_n;
					cnt_q <= cnt_q + 6'd1;
					if (cor_done) begin
						state_q <= S_DVL;
					end
				end
				S_DVL: begin
					aneg_q  <= sin_w[33] ^ kneg_q;
					dn_q    <= psmag_w;
					dr_q    <= '0;
					dd_q    <= kmag_q;
					cnt_q   <= '0;
					state_q <= S_DIV2;
				end
				S_DIV2: begin
					dn_q  <= dn_n;
					dr_q  <= dr_n;
					cnt_q <= cnt_q + 6'd1;
					if (div_done) begin
						a_q     <= q_w;
						aneg_q  <= 1'b1;
						mneg_q  <= 1'b0;
						state_q <= S_SA;
					end
				end
				S_CR2: begin
					cx_q  <= cx_n;
					cy_q  <= cy_n;
					cz_q  <= cz_n;
					cnt_q <= cnt_q + 6'd1;
					if (cor_done) begin
						state_q <= S_M5L;
					end
				end
				S_M5L: begin
					ma_q    <= {amag_w, 12'd0};
					mb_q    <= {6'd0, cmag_w};
					mneg_q  <= a_q[35] ^ cos_w[33];
					acc_q   <= '0;
					mnd_q   <= 4'd9;
					cnt_q   <= '0;
					state_q <= S_M5;
				end
				S_M5: begin
					acc_q <= acc_n;
					ma_q  <= {ma_q[MUL_AW-5:0], 4'd0};
					cnt_q <= cnt_q + 6'd1;
					if (mul_done) begin
						state_q <= S_M5R;
					end
				end
				S_M5R: begin
					dx_q    <= rnd_w[69:30];
					ma_q    <= {amag_w, 12'd0};
					mb_q    <= {6'd0, smag_w};
					mneg_q  <= a_q[35] ^ sin_w[33];
					acc_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_M6;
				end
				S_M6: begin
					acc_q <= acc_n;
					ma_q  <= {ma_q[MUL_AW-5:0], 4'd0};
					cnt_q <= cnt_q + 6'd1;
					if (mul_done) begin
						state_q <= S_M6R;
					end
				end
				S_M6R: begin
					dy_q    <= rnd_w[69:30];
					state_q <= S_SUM;
				end
				S_SUM: begin
					px_q       <= satx_w;
					py_q       <= saty_w;
					last_q     <= (idx_q == count_q - CW'(1));
					trunc_q    <= cut_q;
					m_tvalid_q <= 1'b1;
					state_q    <= S_EMIT;
				end
				S_EMIT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= S_PT;
						end
					end
				end
				default: begin
					state_q    <= S_IDLE;
					m_tvalid_q <= 1'b0;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {py_q, px_q};
	assign m_tlast  = last_q;
	assign m_tuser  = trunc_q;

endmodule

/* tb/tb_road_segment_point_sampler_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Road segment point sampler testbench
// Drives line and arc segments into the sampler under several step settings,
// predicts every sample point with an independent fixed-point model of the
// sampler and compares the point stream field by field. Both stream sides
// idle at random, and the step register is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_road_segment_point_sampler_unit;

	import rsps_pkg::*;

	localparam int NUM_RANDOM = 290;
	localparam int SETTLE_CYCLES = 300;

	// One segment as carried on the input stream.
	typedef struct {
		logic        is_arc;
		logic [31:0] x0;
		logic [31:0] y0;
		logic [15:0] heading;
		logic [23:0] length;
		logic [23:0] curv;
	} segment_t;

	// One sample point as carried on the output stream.
	typedef struct {
		logic [31:0] px;
		logic [31:0] py;
		logic        last;
		logic        cut;
	} sample_point_t;

	// A directed row; when spot_on is set the single expected point is the
	// start point itself, which holds for every segment of zero length.
	typedef struct {
		segment_t seg;
		bit       spot_on;
	} directed_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;   // start_x, start_y, heading, seg_length, curvature
	logic [0:0]   s_tuser;   // req_type
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;   // point_x, point_y
	logic         m_tlast;   // last
	logic [0:0]   m_tuser;   // truncated
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	road_segment_point_sampler_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Arctangent of 2^-i in 2^32 units per turn, for the rotation model.
	localparam longint ATAN_STEP [0:23] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};
	localparam longint CORDIC_GAIN = 652032874;
	localparam longint unsigned ONE_OVER_PI_Q40 = 64'd349985421133;

	sample_point_t pending_points[$];
	logic [15:0]   step_reg;
	int            mismatch_count;
	int            points_seen;
	int            segments_sent;
	int            capped_segments;
	logic [15:0]   ready_pattern;
	int            ready_phase;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Hard limit on the whole run, far beyond the slowest correct run.
	initial begin
		#200ms;
		$display("timeout waiting for sample points");
		$display("road_segment_point_sampler_unit: mismatch");
		$finish;
	end

	// Rotation by a 32-bit turn fraction: the quadrant is folded out first,
	// then a fixed number of shift-and-add steps on the residual angle.
	function automatic void rotate_turn(input logic [31:0] ang, output longint cos_q30,
			output longint sin_q30);
		logic [31:0] quad;
		logic [31:0] resid;
		longint      z;
		longint      xr;
		longint      yr;
		longint      dx;
		longint      dy;
		begin
			quad = ((ang + 32'h2000_0000) >> 30) & 32'd3;
			resid = ang - (quad << 30);
			z = longint'($signed(resid));
			xr = CORDIC_GAIN;
			yr = 0;
			for (int i = 0; i < ANGLE_ITER_DEF && i < TABLE_LEN; i++) begin
				dx = yr >>> i;
				dy = xr >>> i;
				if (z >= 0) begin
					xr = xr - dx;
					yr = yr + dy;
					z = z - ATAN_STEP[i];
				end else begin
					xr = xr + dx;
					yr = yr - dy;
					z = z + ATAN_STEP[i];
				end
			end
			case (quad)
				32'd0: begin
					cos_q30 = xr;
					sin_q30 = yr;
				end
				32'd1: begin
					cos_q30 = -yr;
					sin_q30 = xr;
				end
				32'd2: begin
					cos_q30 = -xr;
					sin_q30 = -yr;
				end
				default: begin
					cos_q30 = yr;
					sin_q30 = -xr;
				end
			endcase
		end
	endfunction

	function automatic logic [31:0] clamp_coord(input longint v);
		begin
			if (v > 64'sd2147483647)
				return 32'h7FFF_FFFF;
			if (v < -64'sd2147483648)
				return 32'h8000_0000;
			return v[31:0];
		end
	endfunction

	// Offset of the point at path position s from the segment start.
	function automatic void path_offset(input segment_t sg, input longint s,
			output longint ox, output longint oy);
		longint               kk;
		longint               prod;
		longint               chord;
		longint               c;
		longint               sn;
		longint               pc;
		longint               ps;
		longint unsigned      mag;
		longint unsigned      hi_part;
		longint unsigned      lo_part;
		longint unsigned      half;
		longint unsigned      half_sq;
		longint unsigned      corr;
		logic [31:0]          r;
		logic [31:0]          phi;
		logic [31:0]          theta;
		begin
			kk = longint'($signed(sg.curv));
			chord = s;
			theta = {sg.heading, 16'h0000};
			if (sg.is_arc && kk != 0) begin
				prod = s * kk;
				mag = (prod < 0) ? -prod : prod;
				hi_part = (mag >> 24) * ONE_OVER_PI_Q40;
				lo_part = (mag & 64'hFF_FFFF) * ONE_OVER_PI_Q40;
				r = 32'((hi_part + (lo_part >> 24)) >> 16);
				phi = (prod < 0) ? (32'd0 - r) : r;
				theta = theta + phi;
				if (mag < (64'd1 << 26)) begin
					// Small arc angle: series form of the chord.
					half = mag >> 1;
					half_sq = (half * half) >> 30;
					corr = ((longint'(s) * half_sq) / 6) >> 30;
					chord = s - longint'(corr);
				end else begin
					rotate_turn(phi, pc, ps);
					chord = (2 * ps) / kk;
				end
			end
			rotate_turn(theta, c, sn);
			ox = (chord * c + (64'sd1 <<< 29)) >>> 30;
			oy = (chord * sn + (64'sd1 <<< 29)) >>> 30;
		end
	endfunction

	// Works out every sample point of one segment and queues them.
	function automatic void predict_segment_points(input segment_t sg);
		longint        stride;
		longint        len;
		longint        whole;
		longint        total;
		longint        s;
		longint        ox;
		longint        oy;
		bit            cut;
		int            count;
		sample_point_t pt;
		begin
			stride = (step_reg == 16'd0) ? 1 : longint'(step_reg);
			len = longint'(sg.length);
			whole = len / stride;
			total = whole + 1 + (((len % stride) != 0) ? 1 : 0);
			cut = total > MAX_POINTS_DEF;
			count = cut ? MAX_POINTS_DEF : int'(total);
			if (cut)
				capped_segments++;
			for (int i = 0; i < count; i++) begin
				s = (i <= whole) ? longint'(i) * stride : len;
				path_offset(sg, s, ox, oy);
				pt.px = clamp_coord(longint'($signed(sg.x0)) + ox);
				pt.py = clamp_coord(longint'($signed(sg.y0)) + oy);
				pt.last = (i == count - 1);
				pt.cut = cut;
				pending_points.push_back(pt);
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		begin
			mismatch_count++;
			$display("%0t point %0d: %s got %0h, expected %0h", $realtime, points_seen,
				what, got, want);
		end
	endtask

	// Output side: every accepted point is held against the oldest one expected.
	always @(posedge clk) begin
		sample_point_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_points.size() == 0) begin
				report_mismatch("unexpected point x", m_tdata[31:0], 32'h0);
			end else begin
				want = pending_points.pop_front();
				if (m_tdata[31:0] !== want.px)
					report_mismatch("point_x", m_tdata[31:0], want.px);
				if (m_tdata[63:32] !== want.py)
					report_mismatch("point_y", m_tdata[63:32], want.py);
				if (m_tlast !== want.last)
					report_mismatch("last", {31'd0, m_tlast}, {31'd0, want.last});
				if (m_tuser[0] !== want.cut)
					report_mismatch("truncated", {31'd0, m_tuser[0]}, {31'd0, want.cut});
			end
			points_seen++;
		end
	end

	// The receiver stalls on a rotating pattern; an all-ones pattern gives
	// stretches with no back-pressure at all.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_phase <= 0;
		end else begin
			m_tready <= ready_pattern[ready_phase];
			ready_phase <= (ready_phase + 1) % 16;
		end
	end

	task automatic write_step(input logic [15:0] value);
		begin
			@(negedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= {REG_SAMPLE_STEP, 2'b00};
			pwdata <= {16'h0000, value};
			@(negedge clk);
			penable <= 1'b1;
			do
				@(posedge clk);
			while (!pready);
			step_reg = value;
			@(negedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= {REG_SAMPLE_STEP, 2'b00};
			pwdata <= 32'h0;
			// Read the register back through the same port.
			@(negedge clk);
			psel <= 1'b1;
			@(negedge clk);
			penable <= 1'b1;
			do
				@(posedge clk);
			while (!pready);
			if (prdata[15:0] !== value)
				report_mismatch("sample_step readback", prdata, {16'h0000, value});
			@(negedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	// Sends one segment and queues its points once the transaction completes.
	// The valid is only lowered when a gap follows, so a back-to-back burst
	// keeps it high without a second assignment in the same step.
	task automatic send_segment(input segment_t sg, input bit spot_on, input int gap);
		sample_point_t pt;
		begin
			@(negedge clk);
			s_tvalid <= 1'b1;
			s_tuser <= sg.is_arc;
			s_tdata <= {sg.curv, sg.length, sg.heading, sg.y0, sg.x0};
			do
				@(posedge clk);
			while (!s_tready);
			if (spot_on) begin
				pt.px = sg.x0;
				pt.py = sg.y0;
				pt.last = 1'b1;
				pt.cut = 1'b0;
				pending_points.push_back(pt);
			end else begin
				predict_segment_points(sg);
			end
			segments_sent++;
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1)
					@(negedge clk);
			end
		end
	endtask

	task automatic drain_points;
		begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			wait (pending_points.size() == 0);
			repeat (SETTLE_CYCLES)
				@(posedge clk);
		end
	endtask

	function automatic logic [31:0] pick_coord;
		begin
			case ($urandom_range(0, 9))
				0: return 32'h7FFF_FFFF - $urandom_range(0, 20000);
				1: return 32'h8000_0000 + $urandom_range(0, 20000);
				2, 3: return $urandom;
				default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			endcase
		end
	endfunction

	function automatic logic [23:0] pick_curvature;
		begin
			case ($urandom_range(0, 9))
				0: return 24'h00_0000;
				1: return 24'(24'h7F_FFFF - $urandom_range(0, 1000));
				2: return 24'(24'h80_0000 + $urandom_range(0, 1000));
				3: return 24'($signed($urandom_range(0, 64)) - 32);
				4, 5: return 24'($urandom);
				default: return 24'($signed($urandom_range(0, 200000)) - 100000);
			endcase
		end
	endfunction

	// Length chosen as a point count times the step plus an optional
	// remainder, so that most segments stay short and a few hit the cap.
	function automatic logic [23:0] pick_length;
		longint stride;
		longint n;
		longint len;
		begin
			stride = (step_reg == 16'd0) ? 1 : longint'(step_reg);
			if ($urandom_range(0, 99) < 4)
				return 24'($urandom);
			if ($urandom_range(0, 99) < 8)
				n = $urandom_range(60, 80);
			else
				n = $urandom_range(0, 10);
			len = n * stride;
			if ($urandom_range(0, 1) == 1)
				len = len + ($urandom % stride);
			if (len > 64'hFF_FFFF)
				len = 64'hFF_FFFF;
			return len[23:0];
		end
	endfunction

	initial begin
		directed_row_t table_rows[$];
		segment_t      sg;
		logic [15:0]   phase_steps[6];
		int            burst_left;
		int            gap;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		ready_pattern = 16'hFFFF;
		step_reg = STEP_RESET;
		mismatch_count = 0;
		points_seen = 0;
		segments_sent = 0;
		capped_segments = 0;
		burst_left = 0;

		// Directed rows: zero length at the coordinate extremes, the cardinal
		// headings, zero curvature on an arc, small and large arc angles, both
		// curvature extremes, remainders, the point cap and saturation.
		table_rows = '{
			'{'{1'b0, 32'h0000_0000, 32'h0000_0000, 16'h0000, 24'h00_0000, 24'h00_0000}, 1},
			'{'{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 24'h00_0000, 24'h7F_FFFF}, 1},
			'{'{1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 24'h00_0000, 24'h80_0000}, 1},
			'{'{1'b0, 32'h0000_0000, 32'h0000_0000, 16'h0000, 24'd3000, 24'h00_0000}, 0},
			'{'{1'b0, 32'h0000_1000, 32'hFFFF_F000, 16'h4000, 24'd2500, 24'h00_0000}, 0},
			'{'{1'b0, 32'h0000_0000, 32'h0000_0000, 16'h8000, 24'd4000, 24'h00_0000}, 0},
			'{'{1'b0, 32'h0000_0000, 32'h0000_0000, 16'hC000, 24'd1999, 24'h00_0000}, 0},
			'{'{1'b0, 32'h0123_4567, 32'h89AB_CDEF, 16'hFFFF, 24'd999, 24'h00_0000}, 0},
			'{'{1'b1, 32'h0000_0000, 32'h0000_0000, 16'h2000, 24'd5000, 24'h00_0000}, 0},
			'{'{1'b1, 32'h0000_0000, 32'h0000_0000, 16'h0000, 24'd3000, 24'h00_0010}, 0},
			'{'{1'b1, 32'h0000_0000, 32'h0000_0000, 16'h0000, 24'd3000, 24'hFF_FFF0}, 0},
			'{'{1'b1, 32'h0000_0000, 32'h0000_0000, 16'h1000, 24'd6000, 24'h7F_FFFF}, 0},
			'{'{1'b1, 32'h0000_0000, 32'h0000_0000, 16'h7000, 24'd6000, 24'h80_0000}, 0},
			'{'{1'b1, 32'hFFF0_0000, 32'h0010_0000, 16'h3456, 24'd7777, 24'h01_0000}, 0},
			'{'{1'b1, 32'h0000_0000, 32'h0000_0000, 16'h0000, 24'd8192, 24'h00_2000}, 0},
			'{'{1'b0, 32'h0000_0000, 32'h0000_0000, 16'h0000, 24'hFF_FFFF, 24'h00_0000}, 0},
			'{'{1'b1, 32'h0000_0000, 32'h0000_0000, 16'h0000, 24'hFF_FFFF, 24'h7F_FFFF}, 0},
			'{'{1'b0, 32'h7FFF_FF00, 32'h0000_0000, 16'h0000, 24'd3000, 24'h00_0000}, 0},
			'{'{1'b0, 32'h0000_0000, 32'h8000_0100, 16'hC000, 24'd3000, 24'h00_0000}, 0},
			'{'{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 16'hA000, 24'd2500, 24'h00_4000}, 0}
		};

		phase_steps = '{16'd1000, 16'd1, 16'hFFFF, 16'd0, 16'd333, 16'd7};

		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 6; ph++) begin
			write_step(phase_steps[ph]);
			case (ph % 3)
				0: ready_pattern = 16'hFFFF;
				1: ready_pattern = 16'($urandom);
				default: ready_pattern = 16'h0F0F | 16'h0001;
			endcase
			if (ready_pattern == 16'h0000)
				ready_pattern = 16'h8001;

			if (ph == 0) begin
				foreach (table_rows[r])
					send_segment(table_rows[r].seg, table_rows[r].spot_on,
						$urandom_range(0, 3));
			end

			for (int n = 0; n < NUM_RANDOM / 6 + ((ph < NUM_RANDOM % 6) ? 1 : 0); n++) begin
				sg.is_arc = ($urandom_range(0, 99) < 60);
				sg.x0 = pick_coord();
				sg.y0 = pick_coord();
				sg.heading = 16'($urandom);
				sg.length = pick_length();
				sg.curv = pick_curvature();
				// Bursts of back-to-back segments separated by random gaps.
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 6);
					gap = $urandom_range(1, 20);
				end else begin
					gap = 0;
				end
				burst_left--;
				if (burst_left != 0)
					gap = 0;
				send_segment(sg, 0, gap);
			end
			drain_points();
		end

		$display("covered %0d segments and %0d points over six step settings,",
			segments_sent, points_seen);
		$display("with %0d segments cut short by the point cap", capped_segments);
		if (mismatch_count == 0)
			$display("road_segment_point_sampler_unit: match");
		else
			$display("road_segment_point_sampler_unit: mismatch");
		$finish;
	end

endmodule

/* road_segment_point_sampler_unit.f */
hdl/rsps_pkg.sv
hdl/road_segment_point_sampler_unit.sv
tb/tb_road_segment_point_sampler_unit.sv
